@@ src/eased_rectangle_zoom_animator_assert.svh @@
// Assertion macros for the eased rectangle zoom animator checker
`ifndef EASED_RECTANGLE_ZOOM_ANIMATOR_ASSERT_SVH
`define EASED_RECTANGLE_ZOOM_ANIMATOR_ASSERT_SVH

// same-cycle implication
`define ERZA_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("erza check failed");

// next-cycle implication
`define ERZA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("erza check failed");

`endif

@@ src/erza_pkg.sv @@
// Shared types, constants and easing tables for the eased rectangle zoom animator
`default_nettype none
package erza_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int TABLE_ENTRIES = 1024;
    localparam int TBL_AW        = 10;
    localparam int COORD_BITS    = 13;

    localparam logic [63:0] Q30        = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] LN2_Q30    = 64'd744261118;

    localparam logic [17:0] EASE_C1 = 18'd111515;
    localparam logic [17:0] EASE_C3 = 18'd177051;

    localparam logic [2:0] MODE_QUAD    = 3'd1;
    localparam logic [2:0] MODE_BACK    = 3'd2;
    localparam logic [2:0] MODE_ELASTIC = 3'd3;

    localparam logic [2:0] REG_START_X  = 3'd0;
    localparam logic [2:0] REG_START_Y  = 3'd1;
    localparam logic [2:0] REG_START_W  = 3'd2;
    localparam logic [2:0] REG_START_H  = 3'd3;
    localparam logic [2:0] REG_TARGET_X = 3'd4;
    localparam logic [2:0] REG_TARGET_Y = 3'd5;
    localparam logic [2:0] REG_TARGET_W = 3'd6;
    localparam logic [2:0] REG_TARGET_H = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SEL,
        ST_IDX,
        ST_ROM,
        ST_EASE,
        ST_LERP,
        ST_OUT
    } state_t;

    typedef logic signed [17:0] tbl_t [TABLE_ENTRIES];

    function automatic tbl_t build_exp();
        tbl_t              t;
        logic [63:0]        z;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        for (int j = 0; j < TABLE_ENTRIES; j++) begin
            z    = (64'(j) * LN2_Q30) / 64'(TABLE_ENTRIES);
            term = Q30;
            sum  = $signed(Q30);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * z) >> 30) / 64'(n);
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            r    = ($unsigned(sum) + 64'd8192) >> 14;
            t[j] = $signed(18'(r));
        end
        return t;
    endfunction

    function automatic tbl_t build_sin();
        tbl_t              t;
        logic signed [63:0] h;
        logic               neg;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        sum;
        logic [63:0]        r;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            h   = $signed((64'(i) * Q30) / 64'(TABLE_ENTRIES));
            neg = 1'b0;
            if (h >= 64'sd536870912) begin
                h = h - $signed(Q30);
            end
            if (h > 64'sd268435456) begin
                h = 64'sd536870912 - h;
            end else if (h < -64'sd268435456) begin
                h = -64'sd536870912 - h;
            end
            if (h < 64'sd0) begin
                neg = 1'b1;
                h   = -h;
            end
            x    = ($unsigned(h) * TWO_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            r    = (sum + 64'd8192) >> 14;
            t[i] = neg ? -$signed(18'(r)) : $signed(18'(r));
        end
        return t;
    endfunction

    localparam tbl_t EXP_TBL = build_exp();
    localparam tbl_t SIN_TBL = build_sin();

endpackage
`default_nettype wire

@@ src/erza_div.sv @@
// Restoring divider, one quotient bit per cycle, sixteen steps
`default_nettype none
module erza_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] rem_init,
    input  wire logic [15:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [15:0]      quotient
);

    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;
    logic [16:0] trial;

    always_comb begin
        shifted   = {rem_reg, quo_reg[15]};
        trial     = shifted - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = rem_init;
            quo_next = dividend;
            cnt_next = 5'd16;
        end else if (cnt_reg != 5'd0) begin
            if (shifted >= {1'b0, divisor}) begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ src/erza_rom.sv @@
// Exponential and sine lookup tables with registered reads
`default_nettype none
module erza_rom import erza_pkg::*; (
    input  wire logic              aclk,
    input  wire logic [TBL_AW-1:0] exp_addr,
    input  wire logic [TBL_AW-1:0] sin_addr,
    output logic signed [17:0]     exp_q,
    output logic signed [17:0]     sin_q
);

    logic signed [17:0] exp_rd_reg;
    logic signed [17:0] sin_rd_reg;

    always_ff @(posedge aclk) begin
        exp_rd_reg <= EXP_TBL[exp_addr];
        sin_rd_reg <= SIN_TBL[sin_addr];
    end

    assign exp_q = exp_rd_reg;
    assign sin_q = sin_rd_reg;

endmodule
`default_nettype wire

@@ src/eased_rectangle_zoom_animator.sv @@
// Eased rectangle zoom animator: sequencer, shared multiplier and result register
// The earliest transfer of a result comes in the cycle after acceptance for a start or for a
// tick while idle; a tick that ends the animation first passes the expiry check. Any other
// tick passes the expiry check, the bit-serial divider that forms the progress, mode
// selection and then products on the single registered 19x19 multiplier. Linear easing
// takes no product for easing, in-out quad one, out-back four, and out-elastic one for the
// sine index plus one table read and one product for easing, unless the progress is zero.
// Every mode then takes four products for the rectangle. The input is not ready until the
// result has been transferred.
`default_nettype none
module eased_rectangle_zoom_animator import erza_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [11:0]            cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_command,
    input  wire logic [31:0]            s_time_ms,
    input  wire logic [15:0]            s_duration_ms,
    input  wire logic [2:0]             s_easing_select,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_running,
    output logic                        m_done_res,
    output logic signed [COORD_BITS-1:0] m_cur_x,
    output logic signed [COORD_BITS-1:0] m_cur_y,
    output logic signed [COORD_BITS-1:0] m_cur_w,
    output logic signed [COORD_BITS-1:0] m_cur_h
);

    localparam logic signed [18:0] THIRD_Q16 = 19'sd21846;

    state_t state_reg, state_next;

    logic signed [11:0] sx_reg, sy_reg, tx_reg, ty_reg;
    logic [10:0]        sw_reg, shgt_reg, tw_reg, thgt_reg;

    logic                         active_reg;
    logic                         done_reg;
    logic [31:0]                  begin_reg;
    logic [15:0]                  length_reg;
    logic [2:0]                   mode_reg;
    logic signed [COORD_BITS-1:0] cur_reg [4];

    logic [31:0]        time_reg;
    logic [15:0]        p_reg;
    logic signed [17:0] ease_reg;
    logic [3:0]         k_reg;
    logic [TBL_AW-1:0]  j_reg;
    logic [TBL_AW-1:0]  i_reg;
    logic [16:0]        s2_reg;
    logic [16:0]        s3_reg;
    logic signed [19:0] acc_reg;
    logic signed [37:0] prod_reg;
    logic [1:0]         step_reg;
    logic               phase_reg;

    logic [31:0]        elapsed;
    logic               expired;
    logic [19:0]        x10;
    logic [20:0]        y_idx;
    logic               half;
    logic [17:0]        u_val;
    logic [16:0]        s_val;
    logic [16:0]        g_val;
    logic               ease_last;
    logic               div_start;
    logic [15:0]        div_rem;
    logic [15:0]        div_dvd;
    logic [15:0]        div_dsr;
    logic               div_done;
    logic [15:0]        div_quo;
    logic signed [17:0] exp_q;
    logic signed [17:0] sin_q;
    logic signed [18:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [12:0] lerp_a;
    logic signed [12:0] lerp_b;
    logic signed [12:0] lerp_d;
    logic signed [23:0] ease_wide;
    logic signed [17:0] ease_clamped;
    logic signed [37:0] lerp_round;
    logic signed [21:0] lerp_sum;
    logic signed [COORD_BITS-1:0] lerp_sat;

    erza_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    erza_rom u_rom (
        .aclk     (aclk),
        .exp_addr (j_reg),
        .sin_addr (i_reg),
        .exp_q    (exp_q),
        .sin_q    (sin_q)
    );

    always_comb begin
        elapsed   = time_reg - begin_reg;
        expired   = elapsed >= {16'd0, length_reg};
        x10       = ({4'd0, p_reg} << 3) + ({4'd0, p_reg} << 1);
        y_idx     = {1'b0, x10} + 21'd147456;
        half      = !p_reg[15];
        u_val     = 18'h20000 - {1'b0, p_reg, 1'b0};
        s_val     = 17'h10000 - {1'b0, p_reg};
        g_val     = exp_q[16:0] >> k_reg;
        ease_last = (mode_reg == MODE_BACK) ? (step_reg == 2'd3) : 1'b1;
        case (step_reg)
            2'd0: begin
                lerp_a = {sx_reg[11], sx_reg};
                lerp_b = {tx_reg[11], tx_reg};
            end
            2'd1: begin
                lerp_a = {sy_reg[11], sy_reg};
                lerp_b = {ty_reg[11], ty_reg};
            end
            2'd2: begin
                lerp_a = {2'b00, sw_reg};
                lerp_b = {2'b00, tw_reg};
            end
            default: begin
                lerp_a = {2'b00, shgt_reg};
                lerp_b = {2'b00, thgt_reg};
            end
        endcase
        lerp_d     = lerp_b - lerp_a;
        lerp_round = prod_reg + 38'sd32768;
        lerp_sum   = {{9{lerp_a[12]}}, lerp_a} + lerp_round[37:16];
        if (lerp_sum < -22'sd4096) begin
            lerp_sat = -13'sd4096;
        end else if (lerp_sum > 22'sd4095) begin
            lerp_sat = 13'sd4095;
        end else begin
            lerp_sat = lerp_sum[12:0];
        end
        if (mode_reg == MODE_BACK) begin
            ease_wide = {{4{acc_reg[19]}}, acc_reg} + $signed({7'd0, prod_reg[32:16]});
        end else begin
            ease_wide = 24'sh10000 + $signed({{2{prod_reg[37]}}, prod_reg[37:16]});
        end
        if (ease_wide < -24'sd131072) begin
            ease_clamped = -18'sd131072;
        end else if (ease_wide > 24'sd131071) begin
            ease_clamped = 18'sd131071;
        end else begin
            ease_clamped = ease_wide[17:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command || !active_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: state_next = expired ? ST_OUT : ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                case (mode_reg)
                    MODE_QUAD:    state_next = ST_EASE;
                    MODE_BACK:    state_next = ST_EASE;
                    MODE_ELASTIC: state_next = (p_reg == 16'd0) ? ST_LERP : ST_IDX;
                    default:      state_next = ST_LERP;
                endcase
            end
            ST_IDX: begin
                if (phase_reg) begin
                    state_next = ST_ROM;
                end
            end
            ST_ROM: state_next = ST_EASE;
            ST_EASE: begin
                if (phase_reg && ease_last) begin
                    state_next = ST_LERP;
                end
            end
            ST_LERP: begin
                if (phase_reg && step_reg == 2'd3) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        m_valid   = (state_reg == ST_OUT);
        cfg_ready = 1'b1;
        div_start = 1'b0;
        div_rem   = elapsed[15:0];
        div_dvd   = 16'd0;
        div_dsr   = length_reg;
        mul_a     = {{6{lerp_d[12]}}, lerp_d};
        mul_b     = {ease_reg[17], ease_reg};
        case (state_reg)
            ST_CHECK: div_start = !expired;
            ST_IDX: begin
                mul_a = {4'd0, y_idx[20:6]};
                mul_b = THIRD_Q16;
            end
            ST_EASE: begin
                case (mode_reg)
                    MODE_QUAD: begin
                        mul_a = half ? {3'd0, p_reg} : {1'b0, u_val};
                        mul_b = mul_a;
                    end
                    MODE_BACK: begin
                        case (step_reg)
                            2'd0: begin
                                mul_a = {2'd0, s_val};
                                mul_b = {2'd0, s_val};
                            end
                            2'd1: begin
                                mul_a = {2'd0, s2_reg};
                                mul_b = {2'd0, s_val};
                            end
                            2'd2: begin
                                mul_a = {1'b0, EASE_C3};
                                mul_b = {2'd0, s3_reg};
                            end
                            default: begin
                                mul_a = {1'b0, EASE_C1};
                                mul_b = {2'd0, s2_reg};
                            end
                        endcase
                    end
                    default: begin
                        mul_a = {2'd0, g_val};
                        mul_b = {sin_q[17], sin_q};
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) begin
                step_reg  <= 2'd0;
                phase_reg <= 1'b0;
            end else if (state_reg == ST_EASE || state_reg == ST_LERP ||
                         state_reg == ST_IDX) begin
                phase_reg <= !phase_reg;
                if (phase_reg) begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg   <= '0;
            sy_reg   <= '0;
            sw_reg   <= '0;
            shgt_reg <= '0;
            tx_reg   <= '0;
            ty_reg   <= '0;
            tw_reg   <= '0;
            thgt_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_X:  sx_reg   <= cfg_data;
                REG_START_Y:  sy_reg   <= cfg_data;
                REG_START_W:  sw_reg   <= cfg_data[10:0];
                REG_START_H:  shgt_reg <= cfg_data[10:0];
                REG_TARGET_X: tx_reg   <= cfg_data;
                REG_TARGET_Y: ty_reg   <= cfg_data;
                REG_TARGET_W: tw_reg   <= cfg_data[10:0];
                REG_TARGET_H: thgt_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            begin_reg  <= 32'd0;
            length_reg <= 16'd1;
            mode_reg   <= 3'd0;
            for (int n = 0; n < 4; n++) begin
                cur_reg[n] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        done_reg <= 1'b0;
                        if (s_command) begin
                            active_reg <= 1'b1;
                            begin_reg  <= s_time_ms;
                            length_reg <= (s_duration_ms == 16'd0) ? 16'd1 : s_duration_ms;
                            mode_reg   <= s_easing_select;
                            cur_reg[0] <= {sx_reg[11], sx_reg};
                            cur_reg[1] <= {sy_reg[11], sy_reg};
                            cur_reg[2] <= {2'b00, sw_reg};
                            cur_reg[3] <= {2'b00, shgt_reg};
                        end
                    end
                end
                ST_CHECK: begin
                    if (expired) begin
                        active_reg <= 1'b0;
                        done_reg   <= 1'b1;
                    end
                end
                ST_LERP: begin
                    if (phase_reg) begin
                        cur_reg[step_reg] <= lerp_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_IDLE) begin
            time_reg <= s_time_ms;
        end
        case (state_reg)
            ST_DIV: begin
                if (div_done) begin
                    p_reg <= div_quo;
                end
            end
            ST_SEL: begin
                k_reg <= x10[19:16];
                j_reg <= x10[15:6];
                if (mode_reg == MODE_ELASTIC || (mode_reg != MODE_QUAD &&
                        mode_reg != MODE_BACK)) begin
                    ease_reg <= (mode_reg == MODE_ELASTIC) ? 18'sd0 : $signed({2'b00, p_reg});
                end
            end
            ST_IDX: begin
                if (phase_reg) begin
                    i_reg <= prod_reg[25:16];
                end
            end
            ST_EASE: begin
                if (phase_reg) begin
                    case (mode_reg)
                        MODE_QUAD: begin
                            if (half) begin
                                ease_reg <= $signed({3'd0, prod_reg[29:15]});
                            end else begin
                                ease_reg <= 18'sh10000 - $signed({1'b0, prod_reg[33:17]});
                            end
                        end
                        MODE_BACK: begin
                            case (step_reg)
                                2'd0: s2_reg <= prod_reg[32:16];
                                2'd1: s3_reg <= prod_reg[32:16];
                                2'd2: acc_reg <= 20'sh10000 - $signed({2'b00, prod_reg[33:16]});
                                default: ease_reg <= ease_clamped;
                            endcase
                        end
                        default: ease_reg <= ease_clamped;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign m_running  = active_reg;
    assign m_done_res = done_reg;
    assign m_cur_x    = cur_reg[0];
    assign m_cur_y    = cur_reg[1];
    assign m_cur_w    = cur_reg[2];
    assign m_cur_h    = cur_reg[3];

endmodule
`default_nettype wire

@@ src/erza_checker.sv @@
// Port-level checks for the eased rectangle zoom animator, bound to the top level
`default_nettype none
`include "eased_rectangle_zoom_animator_assert.svh"
module erza_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_running,
    input wire logic               m_done_res,
    input wire logic signed [12:0] m_cur_x
);

    `ERZA_ASSERT_SAME(a_no_overlap, s_ready, !m_valid)
    `ERZA_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready, !s_ready)
    `ERZA_ASSERT_SAME(a_done_stops, m_valid && m_done_res, !m_running)
    `ERZA_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_cur_x))

endmodule

bind eased_rectangle_zoom_animator erza_checker u_erza_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_running  (m_running),
    .m_done_res (m_done_res),
    .m_cur_x    (m_cur_x)
);
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the eased rectangle zoom animator with its own easing predictor
`default_nettype none
module tb_top import erza_pkg::*;;

    localparam longint unsigned ONE_Q30  = 64'd1 << 30;
    localparam longint unsigned LN2_FX   = 64'd744261118;
    localparam longint unsigned TWOPI_FX = 64'd6746518852;
    localparam longint          UNIT     = 64'sd65536;
    localparam int              WATCHDOG = 20000;

    typedef enum logic {CMD_TICK = 1'b0, CMD_START = 1'b1} cmd_e;

    typedef struct packed {
        logic                         running;
        logic                         done_res;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] w;
        logic signed [COORD_BITS-1:0] h;
    } frame_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [2:0]                   cfg_index;
    logic [11:0]                  cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_command;
    logic [31:0]                  s_time_ms;
    logic [15:0]                  s_duration_ms;
    logic [2:0]                   s_easing_select;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_running;
    logic                         m_done_res;
    logic signed [COORD_BITS-1:0] m_cur_x;
    logic signed [COORD_BITS-1:0] m_cur_y;
    logic signed [COORD_BITS-1:0] m_cur_w;
    logic signed [COORD_BITS-1:0] m_cur_h;

    eased_rectangle_zoom_animator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_time_ms(s_time_ms), .s_duration_ms(s_duration_ms),
        .s_easing_select(s_easing_select),
        .m_valid(m_valid), .m_ready(m_ready), .m_running(m_running),
        .m_done_res(m_done_res), .m_cur_x(m_cur_x), .m_cur_y(m_cur_y),
        .m_cur_w(m_cur_w), .m_cur_h(m_cur_h)
    );

    // animator state as predicted
    longint      rect_from [4];
    longint      rect_to   [4];
    logic        anim_on;
    logic [31:0] anim_t0;
    logic [31:0] anim_len;
    logic [2:0]  anim_mode;
    longint      anim_rect [4];
    longint      exp_rom   [TABLE_ENTRIES];
    longint      sin_rom   [TABLE_ENTRIES];

    frame_t      frames_due [$];
    int          errors;
    int          sent;
    int          idle_cycles;
    bit          gaps_on;
    bit          stalls_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint exp_q(int j);
        longint unsigned z;
        longint unsigned term;
        longint          sum;
        z    = (longint'(j) * LN2_FX) / TABLE_ENTRIES;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * z) >> 30) / n;
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return (sum + 8192) >>> 14;
    endfunction

    function automatic longint sin_q(int i);
        longint          ph;
        bit              neg;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        ph  = (longint'(i) * longint'(ONE_Q30)) / TABLE_ENTRIES;
        neg = 1'b0;
        if (ph >= (64'sd1 << 29)) ph = ph - longint'(ONE_Q30);
        if (ph > (64'sd1 << 28)) begin
            ph = (64'sd1 << 29) - ph;
        end else if (ph < -(64'sd1 << 28)) begin
            ph = -(64'sd1 << 29) - ph;
        end
        if (ph < 0) begin
            neg = 1'b1;
            ph  = -ph;
        end
        x    = (longint'(ph) * TWOPI_FX) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return neg ? -longint'((sum + 8192) >> 14) : longint'((sum + 8192) >> 14);
    endfunction

    function automatic longint eased(longint p, logic [2:0] mode);
        longint e;
        longint u;
        longint s;
        longint s2;
        longint s3;
        longint x;
        longint k;
        longint j;
        longint i;
        longint g;
        case (mode)
            MODE_QUAD: begin
                if (p < UNIT / 2) begin
                    e = (2 * p * p) >>> 16;
                end else begin
                    u = 2 * UNIT - 2 * p;
                    e = UNIT - ((u * u) >>> 17);
                end
            end
            MODE_BACK: begin
                s  = UNIT - p;
                s2 = (s * s) >>> 16;
                s3 = (s2 * s) >>> 16;
                e  = UNIT - ((longint'(EASE_C3) * s3) >>> 16)
                     + ((longint'(EASE_C1) * s2) >>> 16);
            end
            MODE_ELASTIC: begin
                if (p == 0) begin
                    e = 0;
                end else begin
                    x = 10 * p;
                    k = x >>> 16;
                    j = ((x % UNIT) * TABLE_ENTRIES) >>> 16;
                    i = ((x + 9 * UNIT / 4) * TABLE_ENTRIES / (3 * UNIT)) % TABLE_ENTRIES;
                    g = exp_rom[j] >>> k;
                    e = UNIT + ((g * sin_rom[i]) >>> 16);
                end
            end
            default: e = p;
        endcase
        if (e < -2 * UNIT) e = -2 * UNIT;
        if (e > 2 * UNIT - 1) e = 2 * UNIT - 1;
        return e;
    endfunction

    function automatic longint blend(longint a, longint b, longint e);
        longint v;
        v = a + (((b - a) * e + UNIT / 2) >>> 16);
        if (v < -(64'sd1 << (COORD_BITS - 1))) v = -(64'sd1 << (COORD_BITS - 1));
        if (v > (64'sd1 << (COORD_BITS - 1)) - 1) v = (64'sd1 << (COORD_BITS - 1)) - 1;
        return v;
    endfunction

    function automatic void predict_frame(cmd_e cmd, logic [31:0] tm, logic [15:0] dur,
                                          logic [2:0] sel);
        frame_t      f;
        logic [31:0] elapsed;
        longint      p;
        longint      e;
        f.done_res = 1'b0;
        if (cmd == CMD_START) begin
            anim_on   = 1'b1;
            anim_t0   = tm;
            anim_len  = (dur == 16'd0) ? 32'd1 : {16'd0, dur};
            anim_mode = sel;
            for (int n = 0; n < 4; n++) anim_rect[n] = rect_from[n];
        end else if (anim_on) begin
            elapsed = tm - anim_t0;
            if (elapsed >= anim_len) begin
                anim_on    = 1'b0;
                f.done_res = 1'b1;
            end else begin
                p = (longint'(elapsed) << 16) / longint'(anim_len);
                e = eased(p, anim_mode);
                for (int n = 0; n < 4; n++) anim_rect[n] = blend(rect_from[n], rect_to[n], e);
            end
        end
        f.running = anim_on;
        f.x       = anim_rect[0][COORD_BITS-1:0];
        f.y       = anim_rect[1][COORD_BITS-1:0];
        f.w       = anim_rect[2][COORD_BITS-1:0];
        f.h       = anim_rect[3][COORD_BITS-1:0];
        frames_due.push_back(f);
    endfunction

    function automatic int pick_gap(bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_item(cmd_e cmd, logic [31:0] tm, logic [15:0] dur, logic [2:0] sel);
        int gap;
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_time_ms       <= tm;
        s_duration_ms   <= dur;
        s_easing_select <= sel;
        do @(posedge aclk); while (!s_ready);
        predict_frame(cmd, tm, dur, sel);
        sent++;
        gap = pick_gap(gaps_on);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < REG_TARGET_X) begin
            rect_from[idx[1:0]] = (idx < REG_START_W) ? longint'($signed(val)) :
                longint'(val[10:0]);
        end else begin
            rect_to[idx[1:0]] = (idx < REG_TARGET_W) ?
                longint'($signed(val)) : longint'(val[10:0]);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_rect(logic [11:0] sx, logic [11:0] sy, logic [11:0] sw,
                             logic [11:0] sh, logic [11:0] tx, logic [11:0] ty,
                             logic [11:0] tw, logic [11:0] th);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_W, sw);
        write_reg(REG_START_H, sh);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_TARGET_W, tw);
        write_reg(REG_TARGET_H, th);
    endtask

    task automatic test_directed();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_item(CMD_TICK, 32'd5, 16'd0, 3'd0);
        drain();
        load_rect(12'h800, 12'h7FF, 12'h000, 12'hFFF, 12'h7FF, 12'h800, 12'h7FF, 12'h000);
        send_item(CMD_START, 32'd0, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd0, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd1, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd2, 16'd0, 3'd0);
        send_item(CMD_START, 32'hFFFF_FFF0, 16'd100, MODE_QUAD);
        send_item(CMD_TICK, 32'hFFFF_FFFF, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd50, 16'd0, 3'd0);
        send_item(CMD_START, 32'd1000, 16'hFFFF, MODE_BACK);
        send_item(CMD_TICK, 32'd9000, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd999, 16'd0, 3'd0);
        send_item(CMD_START, 32'd200, 16'd1000, MODE_ELASTIC);
        send_item(CMD_TICK, 32'd200, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd210, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd480, 16'd0, 3'd0);
        send_item(CMD_START, 32'd300, 16'd1, 3'd4);
        send_item(CMD_TICK, 32'd300, 16'd0, 3'd0);
        send_item(CMD_START, 32'd300, 16'd10, 3'd7);
        send_item(CMD_TICK, 32'd305, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd310, 16'd0, 3'd0);
        send_item(CMD_TICK, 32'd311, 16'd0, 3'd0);
        drain();
    endtask

    task automatic test_random_phase(int n_items);
        int          start_cnt;
        logic [31:0] t0;
        logic [31:0] el;
        logic [15:0] dur;
        int          ticks;
        bit          extreme;
        extreme = ($urandom_range(0, 3) == 0);
        if (extreme) begin
            load_rect(12'h800, 12'h7FF, 12'hFFF, 12'h000, 12'h7FF, 12'h800, 12'h000, 12'hFFF);
        end else begin
            load_rect(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                      12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        end
        gaps_on   = ($urandom_range(0, 4) != 0);
        stalls_on = ($urandom_range(0, 4) != 0);
        start_cnt = sent;
        while (sent - start_cnt < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(cmd_e'($urandom_range(0, 1)), $urandom, 16'($urandom),
                          3'($urandom));
            end else begin
                t0  = $urandom;
                dur = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 65535)) :
                      16'($urandom_range(1, 400));
                send_item(CMD_START, t0, dur,
                          ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3)));
                el    = 32'd0;
                ticks = $urandom_range(1, 12);
                for (int n = 0; n < ticks; n++) begin
                    el = el + $urandom_range(0, dur / 6 + 1);
                    if (n == ticks - 1 && $urandom_range(0, 1)) el = {16'd0, dur};
                    send_item(CMD_TICK, t0 + el, 16'($urandom), 3'($urandom));
                end
            end
        end
        drain();
    endtask

    initial begin
        int n_phase;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = 3'd0;
        cfg_data        = 12'd0;
        s_valid         = 1'b0;
        s_command       = 1'b0;
        s_time_ms       = 32'd0;
        s_duration_ms   = 16'd0;
        s_easing_select = 3'd0;
        errors          = 0;
        sent            = 0;
        gaps_on         = 1'b0;
        stalls_on       = 1'b0;
        anim_on         = 1'b0;
        anim_t0         = 32'd0;
        anim_len        = 32'd1;
        anim_mode       = 3'd0;
        for (int n = 0; n < 4; n++) begin
            rect_from[n] = 0;
            rect_to[n]   = 0;
            anim_rect[n] = 0;
        end
        for (int n = 0; n < TABLE_ENTRIES; n++) begin
            exp_rom[n] = exp_q(n);
            sin_rom[n] = sin_q(n);
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        while (sent < 1950) begin
            n_phase = $urandom_range(60, 180);
            if (n_phase > 1950 - sent) n_phase = 1950 - sent;
            test_random_phase(n_phase);
        end
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // result side stalls
    initial begin
        int hold;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            hold = pick_gap(stalls_on);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        frame_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                report("unexpected transfer", 1, 0);
            end else begin
                want = frames_due.pop_front();
                if (m_running !== want.running) report("running", m_running, want.running);
                if (m_done_res !== want.done_res) report("done_res", m_done_res, want.done_res);
                if (m_cur_x !== want.x) report("cur_x", m_cur_x, want.x);
                if (m_cur_y !== want.y) report("cur_y", m_cur_y, want.y);
                if (m_cur_w !== want.w) report("cur_w", m_cur_w, want.w);
                if (m_cur_h !== want.h) report("cur_h", m_cur_h, want.h);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
`default_nettype wire
